// ===== rtl/spq_pkg.sv =====
package spq_pkg;

   // Default sizes of the queue.
   localparam int DEPTH_DEF     = 16;
   localparam int KEY_WIDTH_DEF = 64;

   // Fixed widths of the stream fields.
   localparam int KEY_BITS    = 64;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;
   localparam int LIMIT_BITS  = 5;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   // Request commands.
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_EXTRACT = 1'b1;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   // Shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;
      logic ext;
   } cell_ctl_type;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell import spq_pkg::*; #(
   parameter int KEY_W = KEY_WIDTH_DEF
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [KEY_W-1:0] new_key,
   input  logic             own_live,
   input  logic             at_end,
   input  logic [KEY_W-1:0] left_key,
   input  logic             left_flag,
   input  logic [KEY_W-1:0] right_key,
   output logic [KEY_W-1:0] key_q,
   output logic             flag
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   // A live cell holding a strictly greater key gives way to the new key.
   assign flag  = own_live & (key_ff > new_key);
   assign key_q = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.ins) begin
         if (left_flag) begin
            key_in = left_key;
         end else if (flag || at_end) begin
            key_in = new_key;
         end
      end else if (ctl.ext) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue built as a chain of key cells.
//
// Requests arrive on the req_ stream: req_tuser carries the command (insert or
// extract minimum) and req_tdata carries the key to insert. Every accepted
// request transaction yields exactly one result transaction on the rsp_
// stream, carrying the status (ok, full or empty), the removed key and the
// occupancy after the request.
//
// The cells hold the keys in ascending order. On an insert every live cell
// compares its key with the new key at once; cells whose left neighbor gave
// way shift right, and the first cell that gives way (or the first free cell)
// loads the new key. On an extract every cell takes its right neighbor's key.
// A request is settled by the key compare in each cell, and the result
// appears in the output register on the next cycle: the block sustains one
// request per cycle while the receiver takes each result as it comes.
//
// If the receiver stalls, the result waits in the output register and the
// request side stops accepting until that result is taken or taken in the
// same cycle. Reset empties the queue and sets the capacity limit to 16;
// the limit may be rewritten through csr_ while the queue is idle.
module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request stream.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [KEY_BITS-1:0]       req_tdata,   // [63:0] key
   input  logic                      req_tuser,   // [0] cmd
   // Result stream.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [71:0]               rsp_tdata,   // [63:0] out_key, [68:64] occupancy
   output logic [STATUS_BITS-1:0]    rsp_tuser,   // [1:0] status
   // Capacity limit register.
   input  logic                      csr_wr_en,
   input  logic [LIMIT_BITS-1:0]     csr_wr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;

   // Control and configuration state.
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  rsp_valid_ff;

   // Result payload registers.
   logic [STATUS_BITS-1:0] status_ff;
   logic [STATUS_BITS-1:0] status_in;
   logic [KEY_WIDTH-1:0]   out_key_ff;
   logic [KEY_WIDTH-1:0]   out_key_in;
   logic [OCC_BITS-1:0]    occ_ff;

   logic                  req_fire;
   logic                  is_full;
   logic                  is_empty;
   logic [KEY_WIDTH-1:0]  new_key;
   cell_ctl_type          ctl;

   logic [KEY_WIDTH-1:0]  key_q [DEPTH];
   logic                  flag  [DEPTH];

   // A new request is taken whenever the output register is free or drains now.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Keys are narrowed to the stored width; upper bits are dropped.
   assign new_key = req_tdata[KEY_WIDTH-1:0];

   // Full when the count reaches the programmed limit or the physical depth.
   assign is_full  = (CMP_W'(count_ff) >= CMP_W'(limit_ff)) ||
                     (count_ff >= CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctl.ins = req_fire && (req_tuser == CMD_INSERT) && !is_full;
   assign ctl.ext = req_fire && (req_tuser == CMD_EXTRACT) && !is_empty;

   // The cell chain. Cell zero always holds the smallest key.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic                 left_flag;
      logic [KEY_WIDTH-1:0] right_key;

      if (i == 0) begin : g_head
         assign left_key  = '0;
         assign left_flag = 1'b0;
      end else begin : g_body
         assign left_key  = key_q[i-1];
         assign left_flag = flag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_key = key_q[i];
      end else begin : g_mid
         assign right_key = key_q[i+1];
      end

      spq_cell #(
         .KEY_W (KEY_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .new_key   (new_key),
         .own_live  (count_ff > CNT_W'(i)),
         .at_end    (count_ff == CNT_W'(i)),
         .left_key  (left_key),
         .left_flag (left_flag),
         .right_key (right_key),
         .key_q     (key_q[i]),
         .flag      (flag[i])
      );
   end

   // Next count and the result of the request being taken.
   always_comb begin
      count_in   = count_ff;
      status_in  = ST_OK;
      out_key_in = '0;
      if (req_tuser == CMD_INSERT) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            out_key_in = key_q[0];
            count_in   = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff  <= status_in;
         out_key_ff <= out_key_in;
         occ_ff     <= OCC_BITS'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, occ_ff, KEY_BITS'(out_key_ff)};

   // The count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   // A granted insert grows the queue by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the queue");

   // A granted extract shrinks the queue by exactly one entry.
   a_extract_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.ext |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("extract did not shrink the queue");

   // A refused or empty result never carries a key.
   a_no_key_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_OK) |-> out_key_ff == '0)
      else $error("key reported on a failed request");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted priority queue.
//
// An initial block fills a queue of pending requests phase by phase. A clocked
// driver offers them on the req_ stream, and at every accepted transaction it
// runs the same request through a queue model kept here. The model is a sorted
// SystemVerilog queue of keys plus the current capacity limit. The model's
// answer is pushed onto a queue of expected results. A clocked monitor pops
// that queue for every result transaction on the rsp_ stream and compares
// status, removed key and occupancy. Between phases the stimulus waits until
// every expected result has come back, so the capacity limit is only
// rewritten while the queue is idle.
module tb;
   import spq_pkg::*;

   typedef struct packed {
      logic                  cmd;
      logic [KEY_BITS-1:0]   key;
   } queue_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [KEY_BITS-1:0]    out_key;
      logic [OCC_BITS-1:0]    occupancy;
   } queue_rsp_type;

   localparam int QUEUE_DEPTH = DEPTH_DEF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [KEY_BITS-1:0]    req_tdata = '0;      // [63:0] key
   logic                   req_tuser = CMD_INSERT; // [0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [71:0]            rsp_tdata;           // [63:0] out_key, [68:64] occupancy
   logic [STATUS_BITS-1:0] rsp_tuser;           // [1:0] status
   logic                   csr_wr_en = 1'b0;
   logic [LIMIT_BITS-1:0]  csr_wr_data = '0;

   sorted_priority_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be offered, and results the queue model predicts.
   queue_req_type        pending_reqs[$];
   queue_rsp_type        expected_rsps[$];

   // Queue model: stored keys in ascending order and the capacity limit.
   logic [KEY_BITS-1:0]  model_keys[$];
   logic [LIMIT_BITS-1:0] model_limit = LIMIT_RESET;

   int                   error_count = 0;
   bit                   req_idle_on = 1'b0;
   bit                   rsp_idle_on = 1'b0;
   int                   hold_orders = 0;   // long receiver holds asked for
   int                   holds_done  = 0;   // long receiver holds started

   // Runs one request through the model and records the result it must give.
   // An insert goes in front of the first stored key that is strictly
   // greater, so equal keys leave in arrival order.
   function automatic void apply_queue_op(logic cmd, logic [KEY_BITS-1:0] key);
      queue_rsp_type rsp;
      int            lim;
      int            pos;
      rsp.status  = ST_OK;
      rsp.out_key = '0;
      lim = (model_limit < QUEUE_DEPTH) ? int'(model_limit) : QUEUE_DEPTH;
      if (cmd == CMD_INSERT) begin
         if (model_keys.size() >= lim) begin
            rsp.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < model_keys.size() && model_keys[pos] <= key)
               pos++;
            model_keys.insert(pos, key);
         end
      end else begin
         if (model_keys.size() == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.out_key = model_keys.pop_front();
         end
      end
      rsp.occupancy = OCC_BITS'(model_keys.size());
      expected_rsps.push_back(rsp);
   endfunction

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_idle(bit enabled);
      int r;
      if (!enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 30);
   endfunction

   // Keys drawn from several families so that equal keys, the extremes and
   // string-like keys all show up often.
   function automatic logic [KEY_BITS-1:0] pick_key();
      logic [KEY_BITS-1:0] key;
      logic [7:0]          ch;
      int                  len;
      key = '0;
      case ($urandom_range(0, 5))
         0: key = KEY_BITS'($urandom_range(0, 7));
         1: key = {$urandom, $urandom};
         2: key = $urandom_range(0, 1) ? '1 : '0;
         3: begin
            // Text key: up to 8 characters, big-endian, zero-padded.
            len = $urandom_range(1, 8);
            for (int i = 0; i < 8; i++) begin
               ch = (i < len) ? 8'(8'h61 + $urandom_range(0, 4)) : 8'h00;
               key = {key[KEY_BITS-9:0], ch};
            end
         end
         4: key = {1'b1, 60'd0, 3'($urandom_range(0, 7))};
         default: key = {32'd0, $urandom};
      endcase
      return key;
   endfunction

   // Request driver: one transaction in flight, refilled from pending_reqs.
   always @(posedge clock) begin : req_driver
      logic          next_valid;
      queue_req_type item;
      int            req_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            apply_queue_op(req_tuser, req_tdata);
            next_valid = 1'b0;
            req_gap = pick_idle(req_idle_on);
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               item = pending_reqs.pop_front();
               req_tdata <= item.key;
               req_tuser <= item.cmd;
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Result monitor: checks every result transaction and paces rsp_tready.
   always @(posedge clock) begin : rsp_monitor
      queue_rsp_type want;
      int            stall_left;
      int            hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no request pending: status %0d out_key %h",
                      rsp_tuser, rsp_tdata[63:0]);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[63:0] !== want.out_key) begin
                  $error("out_key: expected %h, got %h", want.out_key, rsp_tdata[63:0]);
                  error_count++;
               end
               if (rsp_tdata[68:64] !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_tdata[68:64]);
                  error_count++;
               end
            end
            stall_left = pick_idle(rsp_idle_on);
         end
         // A long hold keeps the result register full so the input stalls.
         if (holds_done < hold_orders && hold_left == 0) begin
            hold_left = 80;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_request(logic cmd, logic [KEY_BITS-1:0] key);
      queue_req_type item;
      item.cmd = cmd;
      item.key = key;
      pending_reqs.push_back(item);
   endtask

   // Waits until every request went out and every result came back, then
   // lets the pipeline settle.
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [LIMIT_BITS-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_limit = value;
   endtask

   initial begin : stimulus
      logic [LIMIT_BITS-1:0] phase_limits[9];
      int                    insert_pct;
      phase_limits = '{5'd31, 5'd16, 5'd1, 5'd5, 5'd0, 5'd16, 5'd3, 5'd12, 5'd17};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty extract, both key extremes, equal keys and a text
      // key, then draining past empty with the reset limit of 16.
      queue_request(CMD_EXTRACT, '1);
      queue_request(CMD_INSERT, '0);
      queue_request(CMD_INSERT, '1);
      queue_request(CMD_INSERT, 64'h6170706C65000000);
      queue_request(CMD_INSERT, '0);
      repeat (5) queue_request(CMD_EXTRACT, '0);

      // A zero limit refuses every insert.
      write_capacity(5'd0);
      queue_request(CMD_INSERT, 64'd7);
      queue_request(CMD_EXTRACT, 64'd7);

      // Fill a limit of two, then lower the limit below the stored count:
      // inserts are refused while extracts still drain the entries.
      write_capacity(5'd2);
      queue_request(CMD_INSERT, 64'd9);
      queue_request(CMD_INSERT, 64'd3);
      queue_request(CMD_INSERT, 64'd1);
      write_capacity(5'd1);
      queue_request(CMD_INSERT, 64'd4);
      repeat (3) queue_request(CMD_EXTRACT, '0);

      // Random phases. Entries carry over from one phase to the next, so a
      // lower limit often starts below the count. Every third phase runs
      // without idle cycles on either side.
      for (int phase = 0; phase < 9; phase++) begin
         write_capacity(phase_limits[phase]);
         req_idle_on = (phase % 3) != 0;
         rsp_idle_on = (phase % 3) != 0;
         insert_pct = (phase % 2 == 0) ? $urandom_range(55, 75) : $urandom_range(30, 50);
         if (phase == 1)
            hold_orders++;
         for (int i = 0; i < 90; i++) begin
            if ($urandom_range(0, 99) < insert_pct)
               queue_request(CMD_INSERT, pick_key());
            else
               queue_request(CMD_EXTRACT, pick_key());
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      if (error_count == 0)
         $display("[sorted_priority_queue] OK");
      else
         $display("[sorted_priority_queue] ERROR");
      $finish;
   end

   initial begin : watchdog
      #3000000;
      $display("[sorted_priority_queue] ERROR");
      $finish;
   end

endmodule
